// File: hdl/llsch_pkg.sv
package llsch_pkg;

    localparam int TASK_SLOTS     = 4;
    localparam int SLOT_COUNT     = TASK_SLOTS + 1;
    localparam int NUM_PARAM_REGS = 4;
    localparam int SLOT_IDX_W     = $clog2(SLOT_COUNT);
    localparam int PARAM_IDX_W    = (NUM_PARAM_REGS > 1) ? $clog2(NUM_PARAM_REGS) : 1;

    localparam int WORK_W     = 16;
    localparam int PERIOD_W   = 16;
    localparam int DEADLINE_W = 18;
    localparam int LAX_W      = DEADLINE_W + 1;
    localparam int PARAM_W    = 48;
    localparam int COUNT_W    = 3;
    localparam int TASK_RUN_W = 3;
    localparam int MISSED_W   = 5;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TASK_PARAM0 = 3'd1;

    localparam logic [WORK_W-1:0]            IDLE_WORK     = 16'd99;
    localparam logic [PERIOD_W-1:0]          IDLE_PERIOD   = 16'd9999;
    localparam logic signed [DEADLINE_W-1:0] IDLE_DEADLINE = 18'sd9999;
    localparam logic signed [DEADLINE_W-1:0] DL_MIN        = 18'sh20000;
    localparam logic signed [LAX_W-1:0]      LAX_LIMIT     = 19'sd65535;
    localparam logic [COUNT_W-1:0]           COUNT_RESET   = COUNT_W'(TASK_SLOTS);

    typedef logic [NUM_PARAM_REGS-1:0][PARAM_W-1:0] params_t;

    typedef struct packed {
        logic [WORK_W-1:0]            work;
        logic [PERIOD_W-1:0]          period;
        logic signed [DEADLINE_W-1:0] deadline;
    } slot_t;

    // laxity compare step control
    typedef struct packed {
        logic                  clear;
        logic                  step;
        logic [SLOT_IDX_W-1:0] init_idx;
        logic [SLOT_IDX_W-1:0] idx;
    } cmp_ctrl_t;

    function automatic logic [SLOT_IDX_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
        logic [SLOT_IDX_W-1:0] r;
        if (int'(c) > TASK_SLOTS)
            r = SLOT_IDX_W'(TASK_SLOTS);
        else
            r = SLOT_IDX_W'(c);
        return r;
    endfunction

    // reload value of slot j: task slots from their register, the idle slot from constants
    function automatic slot_t load_values(input logic [SLOT_IDX_W-1:0] j,
                                          input logic [SLOT_IDX_W-1:0] n,
                                          input params_t p);
        slot_t s;
        logic [PARAM_W-1:0] v;
        v = '0;
        if (j < n) begin
            if (int'(j) < NUM_PARAM_REGS)
                v = p[PARAM_IDX_W'(j)];
            s.work     = v[15:0];
            s.period   = v[31:16];
            s.deadline = $signed({2'b00, v[47:32]});
        end else begin
            s.work     = IDLE_WORK;
            s.period   = IDLE_PERIOD;
            s.deadline = IDLE_DEADLINE;
        end
        return s;
    endfunction

endpackage

// File: hdl/llsch_slot_file.sv
module llsch_slot_file (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [llsch_pkg::SLOT_IDX_W-1:0] idx,
    input  logic                            wr_en,
    input  llsch_pkg::slot_t                wr_data,
    output llsch_pkg::slot_t                rd_data
);
    import llsch_pkg::*;

    slot_t slot_reg [SLOT_COUNT];

    // single shared port: read and write at the sequencer's index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                slot_reg[k] <= '0;
            end
        end
        else if (wr_en)
        begin
            slot_reg[idx] <= wr_data;
        end
    end

    assign rd_data = slot_reg[idx];

endmodule

// File: hdl/llsch_lax_cmp.sv
module llsch_lax_cmp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  llsch_pkg::cmp_ctrl_t                     ctrl,
    input  logic [llsch_pkg::WORK_W-1:0]             work,
    input  logic signed [llsch_pkg::DEADLINE_W-1:0]  deadline,
    output logic [llsch_pkg::SLOT_IDX_W-1:0]         chosen,
    output logic                                     found
);
    import llsch_pkg::*;

    logic signed [LAX_W-1:0]  best_reg, best_next;
    logic [SLOT_IDX_W-1:0]    chosen_reg, chosen_next;
    logic                     found_reg, found_next;
    logic signed [LAX_W-1:0]  lax;

    // one subtract and one signed compare, reused for every slot
    assign lax = $signed({deadline[DEADLINE_W-1], deadline}) -
                 $signed({{(LAX_W-WORK_W){1'b0}}, work});

    always_comb
    begin
        best_next   = best_reg;
        chosen_next = chosen_reg;
        found_next  = found_reg;
        priority if (ctrl.clear)
        begin
            best_next   = LAX_LIMIT;
            chosen_next = ctrl.init_idx;
            found_next  = 1'b0;
        end
        else if (ctrl.step && (work != '0) && (lax < best_reg))
        begin
            best_next   = lax;
            chosen_next = ctrl.idx;
            found_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg   <= LAX_LIMIT;
            chosen_reg <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            best_reg   <= best_next;
            chosen_reg <= chosen_next;
            found_reg  <= found_next;
        end
    end

    assign chosen = chosen_reg;
    assign found  = found_reg;

endmodule

// File: hdl/least_laxity_scheduler_tick.sv
// After the input transfer the sequencer walks slots 0 to n, n = latched task count, in a scan pass
// and again in an update pass, then registers the result once the output register is free; the block
// takes no new tick meanwhile. Each pass walks every slot through the one-port slot file: the scan pass
// through the shared laxity comparator, the update pass through the countdown update.
// Reset (rst_n low, asynchronous): slots clear to zero, task_count returns to 4,
// task parameters clear, the latched count becomes 4 and no result is pending.
module least_laxity_scheduler_tick (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [llsch_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [llsch_pkg::PARAM_W-1:0]       cfg_data,
    // tick input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] restart, [7:1] zero
    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata    // [2:0] task_run, [7:3] missed_mask
);
    import llsch_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    logic [SLOT_IDX_W-1:0] active_n_reg, active_n_next;
    logic                  restart_reg, restart_next;
    logic [MISSED_W-1:0]   missed_reg, missed_next;

    logic [COUNT_W-1:0]    task_count_reg;
    params_t               params_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [7:0]            m_tdata_reg, m_tdata_next;

    cmp_ctrl_t             cmp_ctrl;
    logic [SLOT_IDX_W-1:0] chosen;
    logic                  found;

    slot_t                 rd_slot;
    slot_t                 cur_slot;
    slot_t                 reload_slot;
    slot_t                 wr_slot;
    logic                  wr_en;

    logic                  in_xfer;
    logic                  last_slot;

    logic [WORK_W-1:0]            upd_work;
    logic [PERIOD_W-1:0]          upd_period;
    logic signed [DEADLINE_W-1:0] upd_deadline;
    logic                         upd_missed;

    // configuration registers: indexes past the parameter list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= COUNT_RESET;
            params_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_TASK_COUNT)
            begin
                task_count_reg <= cfg_data[COUNT_W-1:0];
            end
            else if (int'(cfg_index) <= NUM_PARAM_REGS)
            begin
                params_reg[PARAM_IDX_W'(cfg_index - REG_TASK_PARAM0)] <= cfg_data;
            end
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign last_slot = (idx_reg == active_n_reg);

    llsch_slot_file u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx     (idx_reg),
        .wr_en   (wr_en),
        .wr_data (wr_slot),
        .rd_data (rd_slot)
    );

    // On a restart tick, the scan pass sees the freshly loaded slot and writes it back.
    assign reload_slot = load_values(idx_reg, active_n_reg, params_reg);
    assign cur_slot    = restart_reg ? reload_slot : rd_slot;

    llsch_lax_cmp u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cmp_ctrl),
        .work     (cur_slot.work),
        .deadline (cur_slot.deadline),
        .chosen   (chosen),
        .found    (found)
    );

    // countdown of one slot in the update pass
    always_comb
    begin
        upd_work = rd_slot.work;
        if (found && (idx_reg == chosen))
        begin
            upd_work = rd_slot.work - WORK_W'(1);
        end
        upd_period = rd_slot.period - PERIOD_W'(1);
        if (rd_slot.deadline != DL_MIN)
            upd_deadline = rd_slot.deadline - DEADLINE_W'(1);
        else
            upd_deadline = rd_slot.deadline;
        upd_missed = (upd_deadline[DEADLINE_W-1] || (upd_deadline == '0)) &&
                     (upd_work != '0);
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        active_n_next = active_n_reg;
        restart_next  = restart_reg;
        missed_next   = missed_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_slot       = cur_slot;
        cmp_ctrl      = '0;
        cmp_ctrl.idx  = idx_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    restart_next = s_tdata[0];
                    if (s_tdata[0])
                    begin
                        active_n_next = clamp_count(task_count_reg);
                    end
                    cmp_ctrl.clear    = 1'b1;
                    cmp_ctrl.init_idx = active_n_next;
                    idx_next          = '0;
                    missed_next       = '0;
                    state_next        = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // compete: one slot through the shared comparator per cycle
                cmp_ctrl.step = 1'b1;
                wr_en         = restart_reg;
                wr_slot       = reload_slot;
                if (last_slot)
                begin
                    idx_next   = '0;
                    state_next = ST_UPDATE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_IDX_W'(1);
                end
            end
            ST_UPDATE:
            begin
                // consume, count down, flag misses, reload expired periods
                wr_en = 1'b1;
                if (upd_period == '0)
                begin
                    wr_slot = reload_slot;
                end
                else
                begin
                    wr_slot.work     = upd_work;
                    wr_slot.period   = upd_period;
                    wr_slot.deadline = upd_deadline;
                end
                if (int'(idx_reg) < MISSED_W)
                begin
                    missed_next[idx_reg] = upd_missed;
                end
                if (last_slot)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {missed_reg, TASK_RUN_W'(chosen)};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            active_n_reg <= SLOT_IDX_W'(TASK_SLOTS);
            restart_reg  <= 1'b0;
            missed_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            active_n_reg <= active_n_next;
            restart_reg  <= restart_next;
            missed_reg   <= missed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the slot walk never leaves the live slots
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_UPDATE) |-> (idx_reg <= active_n_reg))
        else $error("slot index beyond idle slot");

    // the latched count never exceeds the slot capacity
    a_count_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_tdata[0] |=> (int'(active_n_reg) <= TASK_SLOTS))
        else $error("latched task count not clamped");

    // a winner is a live slot; with no winner the idle index is reported
    a_chosen_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> ((chosen <= active_n_reg) &&
                                    (found || (chosen == active_n_reg))))
        else $error("chosen slot inconsistent");

    // a finished tick never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg)
        else $error("pending result dropped");

endmodule
